// File: src/skid_steer_wheel_drive_controller_assert.svh
// ----------------------------------------------------------------------------
// skid steer wheel drive controller assertion macros
// concurrent checks on clk with arst_n, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef SKID_STEER_WHEEL_DRIVE_CONTROLLER_ASSERT_SVH
`define SKID_STEER_WHEEL_DRIVE_CONTROLLER_ASSERT_SVH
`ifndef SYNTHESIS
`define SSWDC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("sswdc check failed");
`define SSWDC_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sswdc check failed");
`else
`define SSWDC_ASSERT(lbl, prop)
`define SSWDC_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

// File: src/sswdc_pkg.sv
// ----------------------------------------------------------------------------
// sswdc_pkg
// types, codes and constant tables of the skid steer wheel drive controller
// ----------------------------------------------------------------------------
package sswdc_pkg;

	localparam int THROTTLE_POINTS = 4;
	localparam int STEER_POINTS    = 7;
	localparam int TBL_SIZE        = THROTTLE_POINTS * STEER_POINTS;
	localparam int TI_W            = $clog2(THROTTLE_POINTS);
	localparam int SI_W            = $clog2(STEER_POINTS);
	localparam int TBL_IDX_W       = $clog2(TBL_SIZE);
	localparam int DIV_STEPS       = 14;
	localparam int DCNT_W          = $clog2(DIV_STEPS);

	localparam logic signed [15:0] CMD_ONE      = 16'sd16384;
	localparam logic [16:0]        EFFORT_LIMIT = 17'd100000;
	localparam logic [15:0]        TICK_MAX     = 16'hFFFF;

	localparam logic [1:0] MODE_THROTTLE = 2'd0;
	localparam logic [1:0] MODE_STEER    = 2'd1;
	localparam logic [1:0] MODE_TICK     = 2'd2;

	localparam logic REG_GAIN  = 1'b0;
	localparam logic REG_LIMIT = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_AREA, ST_AREA_LD, ST_WGT, ST_TAB, ST_ACC,
		ST_DIV_INIT, ST_DIV, ST_DIV_END, ST_EMUL, ST_ERND, ST_DONE
	} sswdc_state_t;

	function automatic logic signed [15:0] thr_bp(input logic [TI_W-1:0] i);
		case (i)
			2'd0: thr_bp = 16'sd0;
			2'd1: thr_bp = 16'sd6554;
			2'd2: thr_bp = 16'sd11469;
			2'd3: thr_bp = 16'sd16384;
			default: thr_bp = 16'sd0;
		endcase
	endfunction

	function automatic logic signed [15:0] steer_bp(input logic [SI_W-1:0] i);
		case (i)
			3'd0: steer_bp = -16'sd16384;
			3'd1: steer_bp = -16'sd11469;
			3'd2: steer_bp = -16'sd6554;
			3'd3: steer_bp = 16'sd0;
			3'd4: steer_bp = 16'sd6554;
			3'd5: steer_bp = 16'sd11469;
			3'd6: steer_bp = 16'sd16384;
			default: steer_bp = 16'sd0;
		endcase
	endfunction

	// linear speed, Q3.12, row major by throttle
	function automatic logic signed [15:0] lin_tab(input logic [TBL_IDX_W-1:0] i);
		case (i)
			5'd0:  lin_tab = 16'sd1638;  5'd1:  lin_tab = 16'sd696;
			5'd2:  lin_tab = 16'sd0;     5'd3:  lin_tab = 16'sd0;
			5'd4:  lin_tab = 16'sd0;     5'd5:  lin_tab = 16'sd696;
			5'd6:  lin_tab = 16'sd1638;  5'd7:  lin_tab = 16'sd573;
			5'd8:  lin_tab = 16'sd655;   5'd9:  lin_tab = 16'sd942;
			5'd10: lin_tab = 16'sd819;   5'd11: lin_tab = 16'sd737;
			5'd12: lin_tab = 16'sd655;   5'd13: lin_tab = 16'sd573;
			5'd14: lin_tab = 16'sd2662;  5'd15: lin_tab = 16'sd2867;
			5'd16: lin_tab = 16'sd3072;  5'd17: lin_tab = 16'sd3277;
			5'd18: lin_tab = 16'sd3072;  5'd19: lin_tab = 16'sd2867;
			5'd20: lin_tab = 16'sd2662;  5'd21: lin_tab = 16'sd4915;
			5'd22: lin_tab = 16'sd5325;  5'd23: lin_tab = 16'sd5734;
			5'd24: lin_tab = 16'sd6144;  5'd25: lin_tab = 16'sd5734;
			5'd26: lin_tab = 16'sd5325;  5'd27: lin_tab = 16'sd4915;
			default: lin_tab = 16'sd0;
		endcase
	endfunction

	// turn rate, Q3.12, row major by throttle
	function automatic logic signed [15:0] turn_tab(input logic [TBL_IDX_W-1:0] i);
		case (i)
			5'd0:  turn_tab = -16'sd4997; 5'd1:  turn_tab = -16'sd983;
			5'd2:  turn_tab = 16'sd0;     5'd3:  turn_tab = 16'sd0;
			5'd4:  turn_tab = 16'sd0;     5'd5:  turn_tab = 16'sd983;
			5'd6:  turn_tab = 16'sd4997;  5'd7:  turn_tab = -16'sd5407;
			5'd8:  turn_tab = -16'sd1393; 5'd9:  turn_tab = -16'sd410;
			5'd10: turn_tab = 16'sd0;     5'd11: turn_tab = 16'sd410;
			5'd12: turn_tab = 16'sd1393;  5'd13: turn_tab = 16'sd5407;
			5'd14: turn_tab = -16'sd5571; 5'd15: turn_tab = -16'sd1556;
			5'd16: turn_tab = -16'sd573;  5'd17: turn_tab = 16'sd0;
			5'd18: turn_tab = 16'sd573;   5'd19: turn_tab = 16'sd1556;
			5'd20: turn_tab = 16'sd5571;  5'd21: turn_tab = -16'sd5734;
			5'd22: turn_tab = -16'sd1720; 5'd23: turn_tab = -16'sd737;
			5'd24: turn_tab = 16'sd0;     5'd25: turn_tab = 16'sd737;
			5'd26: turn_tab = 16'sd1720;  5'd27: turn_tab = 16'sd5734;
			default: turn_tab = 16'sd0;
		endcase
	endfunction

endpackage

// File: src/skid_steer_wheel_drive_controller.sv
// ----------------------------------------------------------------------------
// skid steer wheel drive controller
// table-mapped throttle/steering to wheel efforts with p control per wheel
// ----------------------------------------------------------------------------
// input beats on s_*: tuser holds the mode (throttle, steering, tick),
// tdata holds command value and the two measured wheel rates.
// throttle and steering beats update their command and give no result.
// a tick beat gives one result beat on m_*: right and left effort in tdata,
// the stale flag in tuser.
// in a tick one shared multiplier forms the cell weights and products (steps
// WGT, TAB and ACC per corner, four corners per table) and a restoring
// divider gives 14 quotient bits per table; each of the two efforts takes
// an EMUL and an ERND step. s_tready is low while a tick is in work.
// when m_tready is low the finished result waits in the output register and
// a new tick is taken, then it holds in its last step until the register frees.
// reset clears both commands and the tick counter and loads gain 1200 and a
// stale limit of 300. registers: wheel_gain at 0x0, stale_limit_ticks at 0x4.
// ----------------------------------------------------------------------------
`include "skid_steer_wheel_drive_controller_assert.svh"

module skid_steer_wheel_drive_controller (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // command_value, right_wheel_speed, left_wheel_speed
	input  logic [1:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // right_effort, left_effort, zero pad
	output logic        m_tuser,   // commands_stale
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sswdc_pkg::*;

	sswdc_state_t state_q, state_d;

	logic signed [15:0] throttle_q, steer_q;
	logic [15:0] tick_cnt_q, gain_q, limit_q;
	logic m_tvalid_q;
	logic [1:0] corner_q;
	logic tbl_q, side_q;
	logic [DCNT_W-1:0] dcnt_q;

	logic signed [44:0] prod_q;
	logic [25:0] area_q;
	logic signed [39:0] acc_q;
	logic [39:0] rem_q, dsh_q;
	logic [DIV_STEPS-1:0] quo_q;
	logic neg_q, stale_q;
	logic signed [15:0] lin_q, ang_q, rspd_q, lspd_q;
	logic signed [17:0] reff_q, leff_q, m_reff_q, m_leff_q;
	logic m_stale_q;

	logic in_acc, cfg_wr, out_load;
	logic signed [15:0] cmd_clamp, t_cl;
	logic [15:0] tick_next;
	logic tick_stale;
	logic [TI_W-1:0] ti, ti1, row;
	logic [SI_W-1:0] si, si1, col;
	logic [13:0] wt, ws, dt, ds, wa, wb;
	logic signed [15:0] d16;
	logic [TBL_IDX_W-1:0] tab_idx;
	logic signed [15:0] tab_val;
	logic signed [27:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [44:0] prod_w;
	logic signed [23:0] lin20, ang15, ref4, err4, spd64;
	logic [39:0] acc_mag;
	logic [44:0] pmag, rsum;
	logic [30:0] rmag;
	logic [16:0] lim;
	logic signed [17:0] eff;

	assign in_acc   = s_tvalid && s_tready;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign prdata   = (paddr[2] == REG_LIMIT) ? {16'b0, limit_q} : {16'b0, gain_q};
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, m_leff_q, m_reff_q};
	assign m_tuser  = m_stale_q;
	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	// command clamp and staleness on the incoming beat
	always_comb begin
		if ($signed(s_tdata[15:0]) > CMD_ONE) begin
			cmd_clamp = CMD_ONE;
		end else if ($signed(s_tdata[15:0]) < -CMD_ONE) begin
			cmd_clamp = -CMD_ONE;
		end else begin
			cmd_clamp = $signed(s_tdata[15:0]);
		end
		tick_next  = (tick_cnt_q == TICK_MAX) ? tick_cnt_q : tick_cnt_q + 16'd1;
		tick_stale = tick_next > limit_q;
	end

	// cell search and weights, reverse throttle reads as zero
	always_comb begin
		t_cl = throttle_q[15] ? 16'sd0 : throttle_q;
		ti = '0;
		for (int i = 1; i < THROTTLE_POINTS - 1; i++) begin
			if (t_cl >= thr_bp(TI_W'(i))) ti = TI_W'(i);
		end
		si = '0;
		for (int i = 1; i < STEER_POINTS - 1; i++) begin
			if (steer_q >= steer_bp(SI_W'(i))) si = SI_W'(i);
		end
		ti1 = ti + TI_W'(1);
		si1 = si + SI_W'(1);
		d16 = thr_bp(ti1) - thr_bp(ti);
		wt  = d16[13:0];
		d16 = steer_bp(si1) - steer_bp(si);
		ws  = d16[13:0];
		d16 = t_cl - thr_bp(ti);
		dt  = d16[13:0];
		d16 = steer_q - steer_bp(si);
		ds  = d16[13:0];
		wa  = corner_q[1] ? dt : wt - dt;
		wb  = corner_q[0] ? ds : ws - ds;
		row = corner_q[1] ? ti1 : ti;
		col = corner_q[0] ? si1 : si;
		tab_idx = TBL_IDX_W'(row) * TBL_IDX_W'(STEER_POINTS) + TBL_IDX_W'(col);
		tab_val = tbl_q ? turn_tab(tab_idx) : lin_tab(tab_idx);
	end

	// wheel rate error, ref4 = 20*v +- 15*w against speed scaled to q12
	always_comb begin
		lin20 = (24'(lin_q) <<< 4) + (24'(lin_q) <<< 2);
		ang15 = (24'(ang_q) <<< 4) - 24'(ang_q);
		ref4  = side_q ? lin20 - ang15 : lin20 + ang15;
		spd64 = side_q ? (24'(lspd_q) <<< 6) : (24'(rspd_q) <<< 6);
		err4  = ref4 - spd64;
	end

	// shared multiplier
	always_comb begin
		case (state_q)
			ST_AREA: begin
				mul_a = signed'({14'b0, wt});
				mul_b = signed'({3'b0, ws});
			end
			ST_WGT: begin
				mul_a = signed'({14'b0, wa});
				mul_b = signed'({3'b0, wb});
			end
			ST_TAB: begin
				mul_a = signed'({2'b0, prod_q[25:0]});
				mul_b = {tab_val[15], tab_val};
			end
			ST_EMUL: begin
				mul_a = 28'(err4);
				mul_b = signed'({1'b0, gain_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod_w = mul_a * mul_b;
	end

	// rounding of the effort product, ties away from zero, then saturation
	always_comb begin
		acc_mag = acc_q[39] ? 40'(-acc_q) : 40'(acc_q);
		pmag    = prod_q[44] ? 45'(-prod_q) : 45'(prod_q);
		rsum    = pmag + 45'd8192;
		rmag    = rsum[44:14];
		lim     = (rmag > 31'(EFFORT_LIMIT)) ? EFFORT_LIMIT : rmag[16:0];
		eff     = prod_q[44] ? -signed'({1'b0, lim}) : signed'({1'b0, lim});
	end

	// sequencer
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == MODE_TICK)) state_d = ST_AREA;
			end
			ST_AREA:    state_d = ST_AREA_LD;
			ST_AREA_LD: state_d = ST_WGT;
			ST_WGT:     state_d = ST_TAB;
			ST_TAB:     state_d = ST_ACC;
			ST_ACC:     state_d = (corner_q == 2'd3) ? ST_DIV_INIT : ST_WGT;
			ST_DIV_INIT: state_d = ST_DIV;
			ST_DIV: begin
				if (dcnt_q == DCNT_W'(DIV_STEPS - 1)) state_d = ST_DIV_END;
			end
			ST_DIV_END: state_d = tbl_q ? ST_EMUL : ST_WGT;
			ST_EMUL:    state_d = ST_ERND;
			ST_ERND:    state_d = side_q ? ST_DONE : ST_EMUL;
			ST_DONE: begin
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			throttle_q <= '0;
			steer_q    <= '0;
			tick_cnt_q <= '0;
			gain_q     <= 16'd1200;
			limit_q    <= 16'd300;
			m_tvalid_q <= 1'b0;
			corner_q   <= '0;
			tbl_q      <= 1'b0;
			side_q     <= 1'b0;
			dcnt_q     <= '0;
		end else begin
			if (cfg_wr) begin
				if (paddr[2] == REG_GAIN) gain_q <= pwdata[15:0];
				else limit_q <= pwdata[15:0];
			end
			if (in_acc) begin
				case (s_tuser)
					MODE_THROTTLE: begin
						throttle_q <= cmd_clamp;
						tick_cnt_q <= '0;
					end
					MODE_STEER: begin
						steer_q    <= cmd_clamp;
						tick_cnt_q <= '0;
					end
					MODE_TICK: begin
						tick_cnt_q <= tick_next;
						tbl_q      <= 1'b0;
						if (tick_stale) begin
							throttle_q <= '0;
							steer_q    <= '0;
						end
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_AREA_LD:  corner_q <= '0;
				ST_ACC:      corner_q <= corner_q + 2'd1;
				ST_DIV_INIT: dcnt_q   <= '0;
				ST_DIV:      dcnt_q   <= dcnt_q + DCNT_W'(1);
				ST_DIV_END: begin
					tbl_q    <= 1'b1;
					side_q   <= 1'b0;
					corner_q <= '0;
				end
				ST_ERND: side_q <= 1'b1;
				default: ;
			endcase
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && (s_tuser == MODE_TICK)) begin
			rspd_q  <= $signed(s_tdata[31:16]);
			lspd_q  <= $signed(s_tdata[47:32]);
			stale_q <= tick_stale;
		end
		case (state_q)
			ST_AREA, ST_WGT, ST_TAB, ST_EMUL: prod_q <= prod_w;
			ST_AREA_LD: begin
				area_q <= prod_q[25:0];
				acc_q  <= '0;
			end
			ST_ACC: acc_q <= acc_q + prod_q[39:0];
			ST_DIV_INIT: begin
				neg_q <= acc_q[39];
				rem_q <= acc_mag + 40'(area_q >> 1);
				dsh_q <= 40'(area_q) << (DIV_STEPS - 1);
				quo_q <= '0;
			end
			ST_DIV: begin
				if (rem_q >= dsh_q) begin
					rem_q <= rem_q - dsh_q;
					quo_q <= {quo_q[DIV_STEPS-2:0], 1'b1};
				end else begin
					quo_q <= {quo_q[DIV_STEPS-2:0], 1'b0};
				end
				dsh_q <= dsh_q >> 1;
			end
			ST_DIV_END: begin
				acc_q <= '0;
				if (tbl_q) ang_q <= neg_q ? -16'(quo_q) : 16'(quo_q);
				else lin_q <= neg_q ? -16'(quo_q) : 16'(quo_q);
			end
			ST_ERND: begin
				if (side_q) leff_q <= eff;
				else reff_q <= eff;
			end
			default: ;
		endcase
		if (out_load) begin
			m_reff_q  <= reff_q;
			m_leff_q  <= leff_q;
			m_stale_q <= stale_q;
		end
	end

	`SSWDC_ASSERT_IMPL(a_busy_no_ready, state_q != ST_IDLE, !s_tready)
	`SSWDC_ASSERT(a_tick_starts, (in_acc && (s_tuser == MODE_TICK)) |=> (state_q == ST_AREA))
	`SSWDC_ASSERT_IMPL(a_div_bound, state_q == ST_DIV, dcnt_q <= DCNT_W'(DIV_STEPS - 1))
	`SSWDC_ASSERT_IMPL(a_stale_zero, (state_q == ST_DONE) && stale_q, (throttle_q == 16'sd0) && (steer_q == 16'sd0))
	`SSWDC_ASSERT_IMPL(a_eff_range, m_tvalid_q, (m_reff_q <= 18'sd100000) && (m_reff_q >= -18'sd100000))

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// skid steer wheel drive controller testbench
// drives throttle, steering, tick and unused-mode beats with random idling, predicts the
// wheel efforts and stale flag of each tick and compares every result beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import sswdc_pkg::*;

	typedef struct packed {
		logic signed [17:0] right;
		logic signed [17:0] left;
		logic               stale;
	} effort_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	skid_steer_wheel_drive_controller dut (.*);

	// predictor state
	int unsigned gain_q = 1200;
	int unsigned limit_q = 300;
	int          thr_q = 0;
	int          str_q = 0;
	int unsigned idle_ticks = 0;

	effort_t efforts_due[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      src_gaps = 1;
	bit      sink_gaps = 1;
	bit      sink_hold = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint div_round(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic int seg_of(int x, bit thr);
		int seg;
		int n;
		seg = 0;
		n = thr ? THROTTLE_POINTS : STEER_POINTS;
		for (int i = 1; i < n - 1; i++) begin
			if (x >= (thr ? int'(thr_bp(TI_W'(i))) : int'(steer_bp(SI_W'(i))))) seg = i;
		end
		return seg;
	endfunction

	function automatic int grid_value(bit turn, int t, int s);
		int ti, si, c;
		longint wt, ws, dt, ds, acc;
		longint v[4];
		t = t < 0 ? 0 : (t > 16384 ? 16384 : t);
		s = s < -16384 ? -16384 : (s > 16384 ? 16384 : s);
		ti = seg_of(t, 1);
		si = seg_of(s, 0);
		wt = int'(thr_bp(TI_W'(ti + 1))) - int'(thr_bp(TI_W'(ti)));
		ws = int'(steer_bp(SI_W'(si + 1))) - int'(steer_bp(SI_W'(si)));
		dt = t - int'(thr_bp(TI_W'(ti)));
		ds = s - int'(steer_bp(SI_W'(si)));
		for (int k = 0; k < 4; k++) begin
			c = (ti + k / 2) * STEER_POINTS + si + k % 2;
			v[k] = turn ? int'(turn_tab(TBL_IDX_W'(c))) : int'(lin_tab(TBL_IDX_W'(c)));
		end
		acc = v[0] * (wt - dt) * (ws - ds) + v[1] * (wt - dt) * ds
			+ v[2] * dt * (ws - ds) + v[3] * dt * ds;
		return int'(div_round(acc, wt * ws));
	endfunction

	function automatic logic signed [17:0] wheel_effort(longint ref4, int speed);
		longint e;
		e = div_round(longint'(gain_q) * (ref4 - longint'(speed) * 64), 16384);
		if (e > 100000) e = 100000;
		if (e < -100000) e = -100000;
		return e[17:0];
	endfunction

	function automatic void predict_beat(logic [1:0] mode, logic [47:0] data);
		int c, lin, ang;
		effort_t r;
		if (mode == MODE_THROTTLE || mode == MODE_STEER) begin
			c = $signed(data[15:0]);
			c = c < -16384 ? -16384 : (c > 16384 ? 16384 : c);
			if (mode == MODE_THROTTLE) thr_q = c;
			else str_q = c;
			idle_ticks = 0;
			return;
		end
		if (mode != MODE_TICK) return;
		if (idle_ticks < 65535) idle_ticks++;
		r.stale = idle_ticks > limit_q;
		if (r.stale) begin
			thr_q = 0;
			str_q = 0;
		end
		lin = grid_value(0, thr_q, str_q);
		ang = grid_value(1, thr_q, str_q);
		r.right = wheel_effort(longint'(lin) * 20 + longint'(ang) * 15,
			$signed(data[31:16]));
		r.left = wheel_effort(longint'(lin) * 20 - longint'(ang) * 15,
			$signed(data[47:32]));
		efforts_due = {efforts_due, r};
	endfunction

	task automatic send_beat(logic [1:0] mode, logic [47:0] data);
		int gap;
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 0;
			gap = $urandom_range(1, 13);
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tuser <= mode;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		predict_beat(mode, data);
	endtask

	task automatic wait_drained();
		s_tvalid <= 0;
		while (efforts_due.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] value);
		psel <= 1;
		pwrite <= 1;
		paddr <= {idx, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (idx == REG_GAIN) gain_q = value;
		else limit_q = value;
		@(posedge clk);
	endtask

	function automatic logic [47:0] rand_data();
		return {16'($urandom), 16'($urandom), 16'($urandom)};
	endfunction

	function automatic logic [47:0] cmd_data(int c);
		logic [15:0] v;
		v = 16'(c);
		return {32'($urandom), v};
	endfunction

	task automatic test_directed();
		int cmds[8] = '{-32768, -16385, -16384, 0, 3277, 11469, 16384, 32767};
		send_beat(MODE_TICK, {16'h7fff, 16'h8000, 16'h0000});
		foreach (cmds[i]) begin
			send_beat(i % 2 ? MODE_STEER : MODE_THROTTLE, cmd_data(cmds[i]));
			send_beat(MODE_TICK, i % 2 ? {16'h8000, 16'h7fff, 16'h0000} : rand_data());
		end
		send_beat(2'd3, rand_data());
		send_beat(MODE_TICK, {16'hffff, 16'hffff, 16'hffff});
		wait_drained();
	endtask

	task automatic test_stale();
		write_reg(REG_LIMIT, 16'd0);
		send_beat(MODE_THROTTLE, cmd_data(12000));
		send_beat(MODE_TICK, rand_data());
		send_beat(MODE_TICK, rand_data());
		wait_drained();
		write_reg(REG_LIMIT, 16'd3);
		send_beat(MODE_STEER, cmd_data(-9000));
		repeat (5) send_beat(MODE_TICK, rand_data());
		wait_drained();
		write_reg(REG_LIMIT, 16'hffff);
		write_reg(REG_GAIN, 16'hffff);
		send_beat(MODE_THROTTLE, cmd_data(16384));
		repeat (4) send_beat(MODE_TICK, rand_data());
		wait_drained();
	endtask

	task automatic test_random(int n, bit no_gaps);
		int r;
		src_gaps = !no_gaps;
		sink_gaps = !no_gaps;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 19);
			if (r < 5) send_beat(MODE_THROTTLE, cmd_data($urandom_range(0, 20000) - 1000));
			else if (r < 9) send_beat(MODE_STEER, cmd_data($urandom_range(0, 36000) - 18000));
			else if (r < 10) send_beat(r[0] ? 2'd3 : MODE_THROTTLE, rand_data());
			else send_beat(MODE_TICK, rand_data());
		end
		wait_drained();
	endtask

	task automatic test_backpressure();
		sink_hold = 1;
		repeat (4) send_beat(MODE_TICK, rand_data());
		wait_drained();
	endtask

	task automatic test_settings();
		logic [15:0] gains[3] = '{16'd0, 16'd1, 16'd40000};
		logic [15:0] lims[3] = '{16'd1, 16'd20, 16'd300};
		foreach (gains[i]) begin
			write_reg(REG_GAIN, gains[i]);
			write_reg(REG_LIMIT, lims[i]);
			test_random(150, 0);
		end
		write_reg(REG_GAIN, 16'd1200);
		write_reg(REG_LIMIT, 16'd5);
		test_random(550, 0);
		test_random(100, 1);
	endtask

	// receiver side ready, with bursts of stall and one long hold
	initial begin
		int gap;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			if (sink_hold) begin
				m_tready <= 0;
				repeat (400) @(posedge clk);
				sink_hold = 0;
			end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 0;
				gap = $urandom_range(1, 13);
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		effort_t exp_r;
		effort_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[17:0], m_tdata[35:18], m_tuser};
			if (efforts_due.size() == 0) begin
				$display("%0t: result beat with none expected, actual %h", $time, got);
				errors++;
			end else begin
				exp_r = efforts_due.pop_front();
				if (got.right !== exp_r.right) begin
					$display("%0t: right_effort expected %0d actual %0d",
						$time, exp_r.right, got.right);
					errors++;
				end
				if (got.left !== exp_r.left) begin
					$display("%0t: left_effort expected %0d actual %0d",
						$time, exp_r.left, got.left);
					errors++;
				end
				if (got.stale !== exp_r.stale) begin
					$display("%0t: commands_stale expected %0d actual %0d",
						$time, exp_r.stale, got.stale);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any accepted beat or register access
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 0;
		s_tvalid = 0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		test_stale();
		test_backpressure();
		test_settings();
		if (errors == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end

endmodule

// File: files.f
+incdir+src
src/sswdc_pkg.sv
src/skid_steer_wheel_drive_controller.sv
verif/tb.sv
